FILE: sv/pfc_pkg.sv
// pfc_pkg: widths, constants and controller/datapath command and status
// structs for the prime factor counter. No dependencies.
package pfc_pkg;

  localparam int VALUE_W   = 32;
  localparam int N_W       = 31;  // magnitude of a non-negative value
  localparam int D_W       = 16;  // trial divisor, at most 46341
  localparam int SQ_W      = 32;  // divisor squared, at most 46341^2
  localparam int CNT_W     = 5;
  localparam int DIV_STEPS = N_W;
  localparam int STEP_W    = 5;
  localparam int MAX_COUNT = 30;

  localparam logic [D_W-1:0]  FIRST_DIV = D_W'(2);
  localparam logic [SQ_W-1:0] FIRST_SQ  = SQ_W'(4);

  typedef struct packed {
    logic load;       // capture a new item
    logic div_start;  // begin dividing n by d
    logic div_step;   // one restoring division step
    logic take_quot;  // d divided n: n = n / d, count one factor
    logic next_div;   // move on to d + 1
    logic finish;     // count a leftover prime
    logic publish;    // copy the count to the output register
  } pfc_cmd_t;

  typedef struct packed {
    logic sq_le_n;    // d * d <= n
    logic rem_zero;   // last division left no remainder
  } pfc_stat_t;

endpackage

FILE: sv/pfc_in_if.sv
// pfc_in_if: input channel carrying the value to factor.
// Depends on nothing.
interface pfc_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

FILE: sv/pfc_out_if.sv
// pfc_out_if: result channel carrying the prime factor count.
// Depends on nothing.
interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] factor_count;

  modport source (output valid, output factor_count, input ready);
  modport sink   (input valid, input factor_count, output ready);
endinterface

FILE: sv/prime_factor_count_top.sv
// Prime factor counter: for each signed 32-bit value returns the number of
// prime factors counted with multiplicity (0 for values below 2), by trial
// division with divisors 2, 3, 4, ... until the divisor squared exceeds the
// remaining value. One item is worked on at a time. Every trial division
// goes through the bit-serial restoring divider and then a compare and an
// update; the largest 31-bit prime needs 46339 trial divisors. The result
// sits in an output register, so the next item is taken while it waits.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if, pfc_ctrl and pfc_dp.
module prime_factor_count_top (
  input  logic      clk,
  input  logic      rst_n,
  pfc_in_if.sink    in_chan,
  pfc_out_if.source out_chan
);
  import pfc_pkg::*;

  pfc_cmd_t  cmd;
  pfc_stat_t stat;

  pfc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_chan.valid),
    .in_ready  (in_chan.ready),
    .out_valid (out_chan.valid),
    .out_ready (out_chan.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfc_dp u_dp (
    .clk       (clk),
    .in_value  (in_chan.value),
    .cmd       (cmd),
    .stat      (stat),
    .out_count (out_chan.factor_count)
  );

  // not ready in the cycle right after taking an item
  assert property (@(posedge clk) disable iff (!rst_n)
    in_chan.valid && in_chan.ready |=> !in_chan.ready)
    else $error("took a second item right after the first");

  // a published count is presented on the next cycle
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.publish |=> out_chan.valid)
    else $error("published count not presented");

  // a 31-bit value never has more than thirty factors
  assert property (@(posedge clk) disable iff (!rst_n)
    out_chan.valid |-> out_chan.factor_count <= CNT_W'(MAX_COUNT))
    else $error("factor count out of range");

  // the divider is never restarted while a new item is captured
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> !(cmd.div_step || cmd.div_start || cmd.take_quot))
    else $error("load collides with division");

endmodule

FILE: sv/pfc_dp.sv
// pfc_dp: datapath of the prime factor counter: remaining value, trial
// divisor and its square, bit-serial restoring divider, count and output.
// Depends on pfc_pkg.
module pfc_dp (
  input  logic                clk,
  input  logic signed [31:0]  in_value,
  input  pfc_pkg::pfc_cmd_t   cmd,
  output pfc_pkg::pfc_stat_t  stat,
  output logic [4:0]          out_count
);
  import pfc_pkg::*;

  logic [N_W-1:0]   n_r;
  logic [D_W-1:0]   d_r;
  logic [SQ_W-1:0]  sq_r;
  logic [CNT_W-1:0] cnt_r;
  logic [N_W-1:0]   q_r;
  logic [D_W-1:0]   rem_r;
  logic [CNT_W-1:0] out_r;

  logic [D_W:0]     part;
  logic [D_W:0]     diff;
  logic             fits;

  // shift in the next dividend bit and try subtracting the divisor
  assign part = {rem_r, q_r[N_W-1]};
  assign diff = part - {1'b0, d_r};
  assign fits = part >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      // negative inputs become zero, which yields no factors
      n_r   <= in_value[VALUE_W-1] ? '0 : in_value[N_W-1:0];
      d_r   <= FIRST_DIV;
      sq_r  <= FIRST_SQ;
      cnt_r <= '0;
    end
    if (cmd.div_start) begin
      q_r   <= n_r;
      rem_r <= '0;
    end
    if (cmd.div_step) begin
      q_r   <= {q_r[N_W-2:0], fits};
      rem_r <= fits ? diff[D_W-1:0] : part[D_W-1:0];
    end
    if (cmd.take_quot) begin
      n_r   <= q_r;
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.next_div) begin
      // (d + 1)^2 = d^2 + 2d + 1
      d_r  <= d_r + D_W'(1);
      sq_r <= sq_r + SQ_W'({d_r, 1'b1});
    end
    if (cmd.finish && (|n_r[N_W-1:1])) begin
      cnt_r <= cnt_r + CNT_W'(1);
    end
    if (cmd.publish) begin
      out_r <= cnt_r;
    end
  end

  assign stat.sq_le_n  = sq_r <= {1'b0, n_r};
  assign stat.rem_zero = rem_r == '0;
  assign out_count     = out_r;

endmodule

FILE: sv/pfc_ctrl.sv
// pfc_ctrl: sequencer of the prime factor counter; runs the trial division
// loop and the handshakes. Depends on pfc_pkg.
module pfc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  pfc_pkg::pfc_stat_t stat,
  output pfc_pkg::pfc_cmd_t  cmd
);
  import pfc_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_CHECK = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_EVAL  = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      S_IDLE: begin
        // no item is taken while reset is held
        in_ready = rst_n;
        if (in_valid && rst_n) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (stat.sq_le_n) begin
          cmd.div_start = 1'b1;
          step_nxt      = '0;
          state_nxt     = S_DIV;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_DONE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DIV_STEPS - 1)) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        // on a hit stay with the same divisor, else try the next one
        if (stat.rem_zero) begin
          cmd.take_quot = 1'b1;
        end else begin
          cmd.next_div = 1'b1;
        end
        state_nxt = S_CHECK;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.publish   = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: test/prime_factor_count_checker.sv
// prime_factor_count_checker: watches the value and count channels, predicts
// the prime factor count of every accepted value and compares it with the
// count that comes back. Depends on pfc_pkg, pfc_in_if and pfc_out_if.
module prime_factor_count_checker (
  input  logic clk,
  input  logic rst_n,
  pfc_in_if    in_mon,
  pfc_out_if   out_mon,
  output int   pending_count,
  output int   fail_count,
  output int   checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [CNT_W-1:0]          count;
  } factor_count_t;

  factor_count_t expected_counts[$];

  // big omega by trial division, leftover above one is a single prime
  function automatic logic [CNT_W-1:0] omega_of(logic signed [VALUE_W-1:0] v);
    logic [N_W-1:0]   rest;
    logic [31:0]      div;
    logic [CNT_W-1:0] cnt;
    cnt = '0;
    if (v >= 2) begin
      rest = v[N_W-1:0];
      div  = 32'(FIRST_DIV);
      while (64'(div) * 64'(div) <= 64'(rest)) begin
        while (rest % div == 0) begin
          rest = N_W'(rest / div);
          cnt++;
        end
        div++;
      end
      if (rest > 1)
        cnt++;
    end
    return cnt;
  endfunction

  always @(posedge clk) begin
    factor_count_t exp_item;
    int            fails;
    int            pend;
    fails = fail_count;
    pend  = pending_count;
    if (!rst_n) begin
      fails = 0;
      pend  = 0;
      expected_counts.delete();
      checked_count <= 0;
    end else begin
      // retire the oldest expectation before queuing a new one
      if (out_mon.valid && out_mon.ready) begin
        if (expected_counts.size() == 0) begin
          $display("%0t: count %0d arrived with no value outstanding",
                   $time, out_mon.factor_count);
          fails++;
        end else begin
          exp_item = expected_counts.pop_front();
          pend--;
          checked_count <= checked_count + 1;
          if (out_mon.factor_count !== exp_item.count) begin
            $display("%0t: value %0d expected count %0d, actual %0d",
                     $time, exp_item.value, exp_item.count, out_mon.factor_count);
            fails++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        exp_item.value  = in_mon.value;
        exp_item.count  = omega_of(in_mon.value);
        expected_counts = {expected_counts, exp_item};
        pend++;
      end
    end
    fail_count    <= fails;
    pending_count <= pend;
  end

endmodule

FILE: test/prime_factor_count_top_tb.sv
// prime_factor_count_top_tb: drives values into the prime factor counter with
// random gaps and result stalls, and reports the verdict of the checker.
// Depends on pfc_pkg, pfc_in_if, pfc_out_if and prime_factor_count_checker.
module prime_factor_count_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfc_pkg::*;

  localparam int RANDOM_ITEMS = 85;
  localparam int QUIET_TAIL   = 20;
  localparam int N_CORNERS    = 19;

  // zero, one, negatives, largest value (a prime), powers, square of a prime
  localparam logic signed [VALUE_W-1:0] CORNER_VALUES [N_CORNERS] = '{
    32'sd0, 32'sd1, 32'sd2, 32'sd3, 32'sd4, -32'sd1, -32'sd2,
    32'sh8000_0000, 32'sh7FFF_FFFF, 32'sd12, 32'sd49, 32'sd1073741824,
    32'sd1162261467, 32'sd2147483646, 32'sd1610612736, 32'sd4093,
    32'sd4095, 32'sd4096, 32'sd4097
  };

  logic clk;
  logic rst_n;
  logic quiet = 1'b0;
  int   stall_left = 0;
  int   pending_count;
  int   fail_count;
  int   checked_count;
  int   n_items = 0;
  int   n_negative = 0;
  int   n_wide = 0;

  pfc_in_if  in_chan ();
  pfc_out_if out_chan ();

  prime_factor_count_top i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  prime_factor_count_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .pending_count (pending_count),
    .fail_count    (fail_count),
    .checked_count (checked_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(200_000_000);
    $display("Test completed with failures");
    $finish;
  end

  // result side stalls in random bursts of low ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left > 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= $urandom_range(0, 2);
    end else begin
      out_chan.ready <= 1'b1;
    end
  end

  task automatic send_value(input logic signed [VALUE_W-1:0] v);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid <= 1'b1;
    in_chan.value <= v;
    do @(posedge clk); while (!in_chan.ready);
    n_items++;
    if (v < 0)
      n_negative++;
    else if (v >= 32'sd16777216)
      n_wide++;
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
  endtask

  // large value built from primes up to 13 and a cofactor below 4096,
  // so trial division stays short
  function automatic logic signed [VALUE_W-1:0] smooth_value();
    logic [63:0] acc;
    logic [63:0] p;
    int          steps;
    acc   = 64'($urandom_range(1, 4095));
    steps = $urandom_range(4, 40);
    for (int k = 0; k < steps; k++) begin
      case ($urandom_range(0, 5))
        0:       p = 64'd2;
        1:       p = 64'd3;
        2:       p = 64'd5;
        3:       p = 64'd7;
        4:       p = 64'd11;
        default: p = 64'd13;
      endcase
      if (acc * p < 64'h8000_0000)
        acc = acc * p;
    end
    return VALUE_W'(acc);
  endfunction

  function automatic logic signed [VALUE_W-1:0] random_value();
    logic [31:0] raw;
    int          w;
    case ($urandom_range(0, 9))
      0, 1, 2: raw = $urandom_range(0, 4095);
      3, 4:    raw = $urandom | 32'h8000_0000;
      5, 6, 7: raw = smooth_value();
      8: begin
        w   = $urandom_range(13, 17);
        raw = $urandom & ((32'd1 << w) - 1);
      end
      default: raw = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 3)
                                                 : -$urandom_range(1, 3);
    endcase
    return raw;
  endfunction

  initial begin
    rst_n          <= 1'b0;
    in_chan.valid  <= 1'b0;
    in_chan.value  <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (CORNER_VALUES[k])
      send_value(CORNER_VALUES[k]);
    drain_results();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i >= RANDOM_ITEMS - QUIET_TAIL)
        quiet <= 1'b1;
      else if (i % 16 == 0)
        quiet <= ($urandom_range(0, 2) == 0);
      if (i == RANDOM_ITEMS / 2)
        drain_results();
      send_value(random_value());
    end
    drain_results();
    repeat (50) @(posedge clk);

    $display("sent %0d values (%0d negative, %0d of 25 bits or more), %0d counts checked",
             n_items, n_negative, n_wide, checked_count);
    $display("corners included zero, one, the most negative value and the largest prime");
    if (fail_count == 0 && pending_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

FILE: prime_factor_count_top.f
sv/pfc_pkg.sv
sv/pfc_in_if.sv
sv/pfc_out_if.sv
sv/pfc_dp.sv
sv/pfc_ctrl.sv
sv/prime_factor_count_top.sv
test/prime_factor_count_checker.sv
test/prime_factor_count_top_tb.sv
